// File: rtl/apd_pkg.sv
`timescale 1ns / 1ps

package apd_pkg;

    localparam int MAX_LENGTH_DEF = 64;
    localparam int Q_DEPTH        = 2;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    localparam logic [7:0] SYNC_HI   = 8'hef;
    localparam logic [7:0] SYNC_LO   = 8'h01;
    localparam logic [7:0] ACK_ID    = 8'h07;
    localparam logic [15:0] MIN_LEN  = 16'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  rx_byte;
        logic [15:0] time_budget;
        logic [5:0]  payload_limit;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [7:0]  confirm_code;
        logic [5:0]  payload_count;
        logic        last;
    } t_out;

    // one completion job handed from parser to emitter
    typedef struct packed {
        logic        success;
        logic [1:0]  status;
        logic [7:0]  confirm;
        logic [5:0]  count;
    } t_job;

endpackage

// File: rtl/apd_queue.sv
`timescale 1ns / 1ps

module apd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  apd_pkg::t_job i_job,
    input  logic          i_pop,
    output apd_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);

    localparam int QAW = (apd_pkg::Q_DEPTH > 1) ? $clog2(apd_pkg::Q_DEPTH) : 1;
    localparam int CW  = $clog2(apd_pkg::Q_DEPTH + 1);

    apd_pkg::t_job r_mem [apd_pkg::Q_DEPTH];
    logic [QAW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]  r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(apd_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    function automatic logic [QAW-1:0] bump(input logic [QAW-1:0] p);
        logic [QAW-1:0] q;
        q = (p == QAW'(apd_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = bump(r_wp);
        end
        if (i_pop) begin
            n_rp = bump(r_rp);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(apd_pkg::Q_DEPTH))
        else $error("queue count beyond depth");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
`endif

endmodule

// File: rtl/apd_front.sv
`timescale 1ns / 1ps

module apd_front #(
    parameter int MAX_LENGTH = apd_pkg::MAX_LENGTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  apd_pkg::t_in                  i_data,
    input  logic                          i_q_full,
    output logic                          o_push,
    output apd_pkg::t_job                 o_job,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_LENGTH)-1:0] o_wr_addr,
    output logic [7:0]                    o_wr_data,
    input  logic                          i_done
);

    localparam int AW    = $clog2(MAX_LENGTH);
    localparam int POS_W = (AW < 3) ? 3 : AW;

    localparam logic [1:0] H_IDLE = 2'd0;
    localparam logic [1:0] H_SEEN = 2'd1;
    localparam logic [1:0] H_HDR  = 2'd2;
    localparam logic [1:0] H_BODY = 2'd3;

    localparam logic [POS_W-1:0] P_ID     = POS_W'(4);
    localparam logic [POS_W-1:0] P_LEN_HI = POS_W'(5);
    localparam logic [POS_W-1:0] P_LEN_LO = POS_W'(6);

    logic             r_active, n_active;
    logic [1:0]       r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_id, n_id;
    logic [7:0]       r_len_hi, n_len_hi;
    logic [POS_W-1:0] r_data_len, n_data_len;
    logic [15:0]      r_sum, n_sum;
    logic [7:0]       r_chk_hi, n_chk_hi;
    logic [15:0]      r_time, n_time;
    logic [5:0]       r_limit, n_limit;
    logic [7:0]       r_confirm, n_confirm;
    logic             r_lock, n_lock;

    logic             accept;
    logic [7:0]       b;
    logic [15:0]      len16;
    logic [POS_W-1:0] bl_m1;
    logic [5:0]       copy;

    assign o_ready = !i_q_full && !r_lock;
    assign accept  = i_valid && o_ready;
    assign b       = i_data.rx_byte;
    assign len16   = {r_len_hi, b};
    assign bl_m1   = r_data_len - 1'b1;
    assign copy    = (16'(bl_m1) > 16'(r_limit)) ? r_limit : 6'(bl_m1);

    assign o_wr_addr = r_pos[AW-1:0];
    assign o_wr_data = b;

    always_comb begin
        n_active   = r_active;
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_id       = r_id;
        n_len_hi   = r_len_hi;
        n_data_len = r_data_len;
        n_sum      = r_sum;
        n_chk_hi   = r_chk_hi;
        n_time     = r_time;
        n_limit    = r_limit;
        n_confirm  = r_confirm;
        n_lock     = r_lock && !i_done;
        o_push     = 1'b0;
        o_job      = '0;
        o_wr_en    = 1'b0;
        if (accept) begin
            unique case (i_data.opcode)
                apd_pkg::OP_START: begin
                    n_active = 1'b1;
                    n_phase  = H_IDLE;
                    n_pos    = '0;
                    n_id     = '0;
                    n_len_hi = '0;
                    n_sum    = '0;
                    n_chk_hi = '0;
                    n_time   = i_data.time_budget;
                    n_limit  = i_data.payload_limit;
                    if (i_data.time_budget == '0) begin
                        n_active     = 1'b0;
                        o_push       = 1'b1;
                        o_job.status = apd_pkg::ST_TIMEOUT;
                    end
                end
                apd_pkg::OP_BYTE: begin
                    if (r_active) begin
                        unique case (r_phase)
                            H_IDLE: begin
                                n_phase = (b == apd_pkg::SYNC_HI) ? H_SEEN : H_IDLE;
                            end
                            H_SEEN: begin
                                if (b == apd_pkg::SYNC_LO) begin
                                    n_phase = H_HDR;
                                    n_pos   = '0;
                                end else begin
                                    n_phase = (b == apd_pkg::SYNC_HI) ? H_SEEN : H_IDLE;
                                end
                            end
                            H_HDR: begin
                                n_pos = r_pos + 1'b1;
                                if (r_pos == P_ID) begin
                                    n_id = b;
                                end else if (r_pos == P_LEN_HI) begin
                                    n_len_hi = b;
                                end else if (r_pos == P_LEN_LO) begin
                                    if (r_id != apd_pkg::ACK_ID || len16 < apd_pkg::MIN_LEN
                                            || len16 > 16'(MAX_LENGTH)) begin
                                        n_active     = 1'b0;
                                        n_phase      = H_IDLE;
                                        o_push       = 1'b1;
                                        o_job.status = apd_pkg::ST_BAD;
                                    end else begin
                                        n_sum      = 16'(r_id) + 16'(r_len_hi) + 16'(b);
                                        n_data_len = POS_W'(len16 - 16'd2);
                                        n_phase    = H_BODY;
                                        n_pos      = '0;
                                    end
                                end
                            end
                            H_BODY: begin
                                if (r_pos < r_data_len) begin
                                    o_wr_en = 1'b1;
                                    n_sum   = r_sum + 16'(b);
                                    n_pos   = r_pos + 1'b1;
                                    if (r_pos == '0) begin
                                        n_confirm = b;
                                    end
                                end else if (r_pos == r_data_len) begin
                                    n_chk_hi = b;
                                    n_pos    = r_pos + 1'b1;
                                end else begin
                                    n_active = 1'b0;
                                    n_phase  = H_IDLE;
                                    o_push   = 1'b1;
                                    if ({r_chk_hi, b} != r_sum) begin
                                        o_job.status = apd_pkg::ST_BAD;
                                    end else begin
                                        o_job.success = 1'b1;
                                        o_job.status  = apd_pkg::ST_OK;
                                        o_job.confirm = r_confirm;
                                        o_job.count   = copy;
                                        n_lock        = 1'b1;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                apd_pkg::OP_TICK: begin
                    if (r_active) begin
                        n_time = (r_time != '0) ? r_time - 1'b1 : '0;
                        if (n_time == '0) begin
                            n_active     = 1'b0;
                            n_phase      = H_IDLE;
                            o_push       = 1'b1;
                            o_job.status = apd_pkg::ST_TIMEOUT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_phase    <= H_IDLE;
            r_pos      <= '0;
            r_id       <= '0;
            r_len_hi   <= '0;
            r_data_len <= '0;
            r_sum      <= '0;
            r_chk_hi   <= '0;
            r_time     <= '0;
            r_limit    <= '0;
            r_lock     <= 1'b0;
        end else begin
            r_active   <= n_active;
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_id       <= n_id;
            r_len_hi   <= n_len_hi;
            r_data_len <= n_data_len;
            r_sum      <= n_sum;
            r_chk_hi   <= n_chk_hi;
            r_time     <= n_time;
            r_limit    <= n_limit;
            r_lock     <= n_lock;
        end
    end

    always_ff @(posedge i_clk) begin
        r_confirm <= n_confirm;
    end

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("job pushed into full queue");
    a_no_write_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> !r_lock)
        else $error("body written while burst drains");
    a_done_when_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> r_lock)
        else $error("burst done without pending burst");
`endif

endmodule

// File: rtl/apd_back.sv
`timescale 1ns / 1ps

module apd_back #(
    parameter int MAX_LENGTH = apd_pkg::MAX_LENGTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  apd_pkg::t_job                 i_job,
    output logic                          o_pop,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_LENGTH)-1:0] i_wr_addr,
    input  logic [7:0]                    i_wr_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output apd_pkg::t_out                 o_data,
    output logic                          o_done
);

    localparam int AW = $clog2(MAX_LENGTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PAY  = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic [7:0]    r_mem [MAX_LENGTH];
    logic [7:0]    r_rd_data;
    logic [1:0]    r_state, n_state;
    apd_pkg::t_job r_job;
    logic [5:0]    r_idx, n_idx;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [6:0]    nxt_idx;
    logic          beat;

    assign beat    = o_valid && i_ready;
    assign nxt_idx = 7'(r_idx) + 7'd1;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = AW'(nxt_idx);
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_job.success && i_job.count != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(1);
                        n_idx   = 6'd1;
                        n_state = S_PAY;
                    end else begin
                        n_state = S_CMP;
                    end
                end
            end
            S_PAY: begin
                if (beat) begin
                    if (r_idx == r_job.count) begin
                        n_state = S_CMP;
                    end else begin
                        rd_en = 1'b1;
                        n_idx = 6'(nxt_idx);
                    end
                end
            end
            S_CMP: begin
                if (beat) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid = (r_state == S_PAY) || (r_state == S_CMP);
    assign o_done  = (r_state == S_CMP) && beat && r_job.success;

    always_comb begin
        o_data = '0;
        if (r_state == S_CMP) begin
            o_data.kind          = apd_pkg::KIND_DONE;
            o_data.status        = r_job.status;
            o_data.confirm_code  = r_job.confirm;
            o_data.payload_count = r_job.count;
            o_data.last          = 1'b1;
        end else begin
            o_data.kind         = apd_pkg::KIND_PAYLOAD;
            o_data.payload_byte = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

`ifndef ASSERT_OFF
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAY) |-> (r_idx != '0 && r_idx <= r_job.count))
        else $error("payload index outside burst");
    a_pay_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAY) |-> r_job.success)
        else $error("payload beat for failed packet");
    a_no_write_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAY) |-> !i_wr_en)
        else $error("body store written during burst");
`endif

endmodule

// File: rtl/ack_packet_deframer.sv
`timescale 1ns / 1ps

// Acknowledgement packet deframer. Each input beat (start, received byte or
// millisecond tick) is taken by the parser, which keeps the header, running
// checksum and timeout and writes body bytes into a MAX_LENGTH-entry body
// memory. Completions pass through a two-entry job queue to the emitter. A
// good packet drains its payload from the body memory at one beat per cycle
// while the receiver is ready, then its completion beat; the first beat
// shows in the cycle after the job leaves the queue. From the accepted
// checksum byte of a good packet until its completion beat is taken, input
// is held off. Error and timeout completions queue without holding off
// input unless the job queue is full.
module ack_packet_deframer #(
    parameter int MAX_LENGTH = apd_pkg::MAX_LENGTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  apd_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output apd_pkg::t_out o_data
);

    localparam int AW = $clog2(MAX_LENGTH);

    logic          q_full;
    logic          q_empty;
    logic          push;
    logic          pop;
    apd_pkg::t_job job_in;
    apd_pkg::t_job job_out;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          done;

    apd_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_job     (job_in),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .i_done    (done)
    );

    apd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    apd_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (q_empty),
        .i_job     (job_out),
        .o_pop     (pop),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data),
        .o_done    (done)
    );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef enum logic [1:0] {
        HUNT_IDLE,
        HUNT_SAW_EF,
        HUNT_HEADER,
        HUNT_BODY
    } t_hunt;

    typedef enum int {
        PK_GOOD,
        PK_BAD_ID,
        PK_BAD_LEN,
        PK_BAD_SUM,
        PK_TIMEOUT,
        PK_RESTART,
        PK_NOISE
    } t_pkt_kind;

    class ack_scoreboard;
        apd_pkg::t_out due_beats[$];
        int            error_count;
        int            effective_items;
        int            payload_beats;
        int            done_by_status[4];
        bit            active;
        t_hunt         hunt;
        int            field_pos;
        logic [7:0]    packet_id;
        logic [15:0]   length_word;
        logic [7:0]    body_mem[apd_pkg::MAX_LENGTH_DEF];
        logic [15:0]   running_sum;
        logic [7:0]    csum_high;
        logic [15:0]   time_left;
        logic [5:0]    limit_held;

        function new();
            error_count     = 0;
            effective_items = 0;
            payload_beats   = 0;
            foreach (done_by_status[k]) done_by_status[k] = 0;
            active      = 1'b0;
            hunt        = HUNT_IDLE;
            field_pos   = 0;
            packet_id   = '0;
            length_word = '0;
            running_sum = '0;
            csum_high   = '0;
            time_left   = '0;
            limit_held  = '0;
        endfunction

        function void push_beat(logic kind, logic [7:0] pb, logic [1:0] st,
                                logic [7:0] cc, logic [5:0] cnt);
            apd_pkg::t_out b;
            b.kind          = kind;
            b.payload_byte  = pb;
            b.status        = st;
            b.confirm_code  = cc;
            b.payload_count = cnt;
            b.last          = (kind == apd_pkg::KIND_DONE);
            due_beats.push_back(b);
        endfunction

        function void abort_packet(logic [1:0] st);
            active = 1'b0;
            hunt   = HUNT_IDLE;
            push_beat(apd_pkg::KIND_DONE, 8'h00, st, 8'h00, 6'd0);
        endfunction

        function void take_byte(logic [7:0] b);
            int data_len;
            int n_copy;
            case (hunt)
                HUNT_IDLE: begin
                    hunt = (b == apd_pkg::SYNC_HI) ? HUNT_SAW_EF : HUNT_IDLE;
                end
                HUNT_SAW_EF: begin
                    if (b == apd_pkg::SYNC_LO) begin
                        hunt      = HUNT_HEADER;
                        field_pos = 0;
                    end else begin
                        hunt = (b == apd_pkg::SYNC_HI) ? HUNT_SAW_EF : HUNT_IDLE;
                    end
                end
                HUNT_HEADER: begin
                    if (field_pos == 6) begin
                        length_word[7:0] = b;
                        if (packet_id != apd_pkg::ACK_ID || length_word < apd_pkg::MIN_LEN
                                || length_word > apd_pkg::MAX_LENGTH_DEF) begin
                            abort_packet(apd_pkg::ST_BAD);
                        end else begin
                            running_sum = 16'(packet_id) + 16'(length_word[15:8])
                                        + 16'(length_word[7:0]);
                            hunt      = HUNT_BODY;
                            field_pos = 0;
                        end
                    end else begin
                        if (field_pos == 4) packet_id = b;
                        if (field_pos == 5) length_word = {b, 8'h00};
                        field_pos++;
                    end
                end
                default: begin
                    data_len = int'(length_word) - 2;
                    if (field_pos < data_len) begin
                        body_mem[field_pos] = b;
                        running_sum += 16'(b);
                        field_pos++;
                    end else if (field_pos == data_len) begin
                        csum_high = b;
                        field_pos++;
                    end else if ({csum_high, b} != running_sum) begin
                        abort_packet(apd_pkg::ST_BAD);
                    end else begin
                        n_copy = data_len - 1;
                        if (n_copy > int'(limit_held)) n_copy = int'(limit_held);
                        for (int k = 0; k < n_copy; k++)
                            push_beat(apd_pkg::KIND_PAYLOAD, body_mem[k + 1], apd_pkg::ST_OK,
                                      8'h00, 6'd0);
                        push_beat(apd_pkg::KIND_DONE, 8'h00, apd_pkg::ST_OK, body_mem[0],
                                  6'(n_copy));
                        active = 1'b0;
                        hunt   = HUNT_IDLE;
                    end
                end
            endcase
        endfunction

        function void note_input(apd_pkg::t_in it);
            case (it.opcode)
                apd_pkg::OP_START: begin
                    effective_items++;
                    active      = 1'b1;
                    hunt        = HUNT_IDLE;
                    field_pos   = 0;
                    packet_id   = '0;
                    length_word = '0;
                    running_sum = '0;
                    csum_high   = '0;
                    time_left   = it.time_budget;
                    limit_held  = it.payload_limit;
                    if (time_left == 0) abort_packet(apd_pkg::ST_TIMEOUT);
                end
                apd_pkg::OP_BYTE: begin
                    if (active) begin
                        effective_items++;
                        take_byte(it.rx_byte);
                    end
                end
                apd_pkg::OP_TICK: begin
                    if (active) begin
                        effective_items++;
                        if (time_left > 0) time_left--;
                        if (time_left == 0) abort_packet(apd_pkg::ST_TIMEOUT);
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            error_count++;
            if (error_count <= 40) $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_output(apd_pkg::t_out got);
            apd_pkg::t_out want;
            if (due_beats.size() == 0) begin
                report_mismatch($sformatf("result beat %h with nothing expected", got));
                return;
            end
            want = due_beats.pop_front();
            if (want.kind == apd_pkg::KIND_PAYLOAD) payload_beats++;
            else done_by_status[want.status]++;
            check_field("kind", 8'(got.kind), 8'(want.kind));
            check_field("payload_byte", got.payload_byte, want.payload_byte);
            check_field("status", 8'(got.status), 8'(want.status));
            check_field("confirm_code", got.confirm_code, want.confirm_code);
            check_field("payload_count", 8'(got.payload_count), 8'(want.payload_count));
            check_field("last", 8'(got.last), 8'(want.last));
        endtask
    endclass

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_ready = 1'b0;
    apd_pkg::t_in  i_data  = '0;
    logic          o_ready;
    logic          o_valid;
    apd_pkg::t_out o_data;

    ack_scoreboard sb = new();

    int sender_idle_pct   = 29;
    int receiver_idle_pct = 64;
    int rx_hold_request   = 0;
    int items_sent        = 0;

    ack_packet_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_request > 0) begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_output(o_data);
    end

    function automatic apd_pkg::t_in make_item(logic [1:0] op, logic [7:0] b,
                                               logic [15:0] tmo, logic [5:0] lim);
        apd_pkg::t_in it;
        it.opcode        = op;
        it.rx_byte       = b;
        it.time_budget   = tmo;
        it.payload_limit = lim;
        return it;
    endfunction

    task automatic send_item(input apd_pkg::t_in item);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(item);
        items_sent++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // unused fields carry junk on purpose
    task automatic send_rx(input logic [7:0] b, input int tick_pct);
        if ($urandom_range(99) < tick_pct)
            send_item(make_item(apd_pkg::OP_TICK, 8'($urandom), 16'($urandom),
                                6'($urandom)));
        send_item(make_item(apd_pkg::OP_BYTE, b, 16'($urandom), 6'($urandom)));
    endtask

    task automatic send_packet(input t_pkt_kind flavour, input int len,
                               input logic [5:0] limit);
        logic [15:0] len_word;
        logic [15:0] sum;
        logic [15:0] tmo;
        logic [7:0]  id;
        logic [7:0]  b;
        int          tick_pct;
        int          stop_at;
        tick_pct = (flavour == PK_TIMEOUT) ? 50 : 4;
        if (flavour == PK_TIMEOUT) tmo = 16'($urandom_range(1, 5));
        else if ($urandom_range(7) == 0) tmo = 16'hffff;
        else tmo = 16'($urandom_range(200, 65535));
        send_item(make_item(apd_pkg::OP_START, 8'($urandom), tmo, limit));
        if (flavour == PK_NOISE) begin
            repeat ($urandom_range(1, 6)) send_rx(8'($urandom), tick_pct);
            send_rx(apd_pkg::SYNC_HI, tick_pct);
            send_rx(8'h5a, tick_pct);
        end
        repeat ($urandom_range(1, 3)) send_rx(apd_pkg::SYNC_HI, tick_pct);
        send_rx(apd_pkg::SYNC_LO, tick_pct);
        repeat (4) send_rx(8'($urandom), tick_pct);
        id = apd_pkg::ACK_ID;
        if (flavour == PK_BAD_ID) begin
            id = 8'($urandom);
            if (id == apd_pkg::ACK_ID) id = 8'h70;
        end
        len_word = 16'(len);
        if (flavour == PK_BAD_LEN) begin
            case ($urandom_range(2))
                0:       len_word = 16'($urandom_range(0, 2));
                1:       len_word = 16'($urandom_range(65, 255));
                default: len_word = {8'($urandom_range(1, 255)), 8'($urandom)};
            endcase
        end
        send_rx(id, tick_pct);
        send_rx(len_word[15:8], tick_pct);
        send_rx(len_word[7:0], tick_pct);
        if (flavour == PK_BAD_ID || flavour == PK_BAD_LEN) return;
        sum     = 16'(id) + 16'(len_word[15:8]) + 16'(len_word[7:0]);
        stop_at = (flavour == PK_RESTART) ? $urandom_range(0, len - 3) : len;
        for (int k = 0; k < len - 2; k++) begin
            if (k == stop_at) return;
            b = 8'($urandom);
            sum += 16'(b);
            send_rx(b, tick_pct);
        end
        if (flavour == PK_BAD_SUM) sum ^= 16'(1) << $urandom_range(15);
        send_rx(sum[15:8], tick_pct);
        send_rx(sum[7:0], tick_pct);
    endtask

    initial begin : stimulus
        logic [7:0] min_pkt[13];
        int         phase_goal;
        int         pkt_no;
        int         waited;
        int         len;
        int         r;
        logic [5:0] limit;
        t_pkt_kind  flavour;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(make_item(apd_pkg::OP_START, 8'h00, 16'h0000, 6'd5));
        send_item(make_item(apd_pkg::OP_BYTE, apd_pkg::SYNC_HI, 16'h0000, 6'd0));
        send_item(make_item(apd_pkg::OP_TICK, 8'hff, 16'hffff, 6'd63));
        send_item(make_item(OP_SPARE, 8'hff, 16'hffff, 6'd63));
        send_item(make_item(apd_pkg::OP_START, 8'hff, 16'd2, 6'd0));
        send_item(make_item(apd_pkg::OP_TICK, 8'h00, 16'h0000, 6'd0));
        send_item(make_item(apd_pkg::OP_TICK, 8'h00, 16'h0000, 6'd0));

        // shortest legal packet behind a doubled sync byte
        min_pkt = '{apd_pkg::SYNC_HI, apd_pkg::SYNC_HI, apd_pkg::SYNC_LO, 8'h00, 8'hff,
                    8'h12, 8'h34, apd_pkg::ACK_ID, 8'h00, 8'h03, 8'hc5, 8'h00, 8'hcf};
        send_item(make_item(apd_pkg::OP_START, 8'h00, 16'hffff, 6'd63));
        foreach (min_pkt[k]) begin
            if (k == 7) begin
                send_item(make_item(OP_SPARE, 8'h00, 16'h0000, 6'd0));
                send_item(make_item(apd_pkg::OP_TICK, 8'h00, 16'h0000, 6'd0));
            end
            send_item(make_item(apd_pkg::OP_BYTE, min_pkt[k], 16'h0000, 6'd0));
        end

        pkt_no = 0;
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct   = (phase == 0) ? 29 : (phase == 1) ? 64 : 0;
            receiver_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 29 : 0;
            phase_goal        = (phase == 0) ? 95 : (phase == 1) ? 150 : 205;
            if (phase == 2) begin
                // long receiver hold-off so the job queue fills and input stalls
                rx_hold_request = 400;
                send_packet(PK_BAD_ID, 8, 6'd10);
                send_item(make_item(apd_pkg::OP_START, 8'h00, 16'h0000, 6'd0));
                send_packet(PK_BAD_LEN, 8, 6'd10);
                send_packet(PK_GOOD, 24, 6'd63);
            end
            while (items_sent < phase_goal) begin
                r = $urandom_range(99);
                if (pkt_no < 7) flavour = t_pkt_kind'(pkt_no);
                else if (r < 50) flavour = PK_GOOD;
                else if (r < 58) flavour = PK_BAD_ID;
                else if (r < 66) flavour = PK_BAD_LEN;
                else if (r < 76) flavour = PK_BAD_SUM;
                else if (r < 84) flavour = PK_TIMEOUT;
                else if (r < 92) flavour = PK_RESTART;
                else flavour = PK_NOISE;
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(3, 14);
                case ($urandom_range(7))
                    0:       limit = 6'd0;
                    1:       limit = 6'd63;
                    default: limit = 6'($urandom);
                endcase
                if (pkt_no == 0) begin
                    len   = 64;
                    limit = 6'd63;
                end
                send_packet(flavour, len, limit);
                pkt_no++;
            end
        end

        release_input();
        waited = 0;
        while (sb.due_beats.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (50) @(posedge i_clk);
        if (sb.due_beats.size() != 0)
            sb.report_mismatch($sformatf("%0d result beats never arrived",
                                         sb.due_beats.size()));

        $display("Run covered %0d packets, %0d input beats, %0d of them effective.",
                 pkt_no, items_sent, sb.effective_items);
        $display("Checked %0d payload beats; completions ok %0d, timeout %0d, bad %0d.",
                 sb.payload_beats, sb.done_by_status[apd_pkg::ST_OK],
                 sb.done_by_status[apd_pkg::ST_TIMEOUT], sb.done_by_status[apd_pkg::ST_BAD]);
        if (sb.error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("Watchdog expired with %0d beats outstanding", sb.due_beats.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/apd_pkg.sv
rtl/apd_queue.sv
rtl/apd_front.sv
rtl/apd_back.sv
rtl/ack_packet_deframer.sv
verif/testbench.sv
